FILE: rtl/tpsd_pkg.sv
package tpsd_pkg;

   // Angle format: one electrical turn is 2^ANGLE_BITS units
   localparam int ANGLE_BITS    = 15;
   localparam int SINE_SPAN     = 8192;
   localparam int TIMER_DIVISOR = 7;

   localparam int TURN        = 1 << ANGLE_BITS;
   localparam int HALF        = TURN / 2;
   localparam int QUARTER     = TURN / 4;
   localparam int THIRD       = TURN / 3;
   localparam int TWO_THIRDS  = (TURN * 2) / 3;
   localparam int SINE_OFFSET = SINE_SPAN / 2;
   localparam int SPAN_SHIFT  = $clog2(SINE_SPAN);

   // Field widths
   localparam int CMD_W   = 15;
   localparam int POWER_W = 14;
   localparam int SINE_W  = 14;
   localparam int DUTY_W  = 11;

   // Cubic sine: sin ~ x * (3*2^15 - x^2/2^11) / 2^17
   localparam int POLY_K     = 3 << 15;
   localparam int POLY_W     = 18;
   localparam int SQ_SHIFT   = 11;
   localparam int POLY_SHIFT = 17;

   // Timer divisor as a reciprocal multiply, exact for levels up to SINE_SPAN
   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int DIV_RECIP = ((1 << DIV_SHIFT) + TIMER_DIVISOR - 1) / TIMER_DIVISOR;

   // Register stages from input beat to output register
   localparam int NUM_STAGES = 6;

   typedef logic        [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [ANGLE_BITS-1:0] fold_type;
   typedef logic signed [CMD_W-1:0]      command_type;
   typedef logic        [POWER_W-1:0]    power_type;
   typedef logic        [DUTY_W-1:0]     duty_type;

   // Advance strobes for the per-phase stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_en_type;

endpackage

FILE: rtl/tpsd_if.sv
// Input channel: angle and command
interface tpsd_req_if;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   tpsd_pkg::angle_type   angle;
   tpsd_pkg::command_type command;

   modport source (output valid, output mode, output angle, output command, input ready);
   modport sink   (input valid, input mode, input angle, input command, output ready);
endinterface

// Result channel: three compare values
interface tpsd_rsp_if;
   logic               valid;
   logic               ready;
   tpsd_pkg::duty_type duty_a;
   tpsd_pkg::duty_type duty_b;
   tpsd_pkg::duty_type duty_c;

   modport source (output valid, output duty_a, output duty_b, output duty_c, input ready);
   modport sink   (input valid, input duty_a, input duty_b, input duty_c, output ready);
endinterface

FILE: rtl/tpsd_phase.sv
// One phase: fold, cubic sine, offset, power scale, timer divide
module tpsd_phase (
   input  logic                   clock,
   input  tpsd_pkg::stage_en_type en,
   input  tpsd_pkg::angle_type    angle,
   input  tpsd_pkg::power_type    power,
   output tpsd_pkg::duty_type     duty
);

   localparam int AW = tpsd_pkg::ANGLE_BITS;
   localparam int PW = tpsd_pkg::POWER_W;

   // Stage 2: fold the angle into -quarter..+quarter
   logic signed [AW:0]  a_wide;
   logic signed [AW:0]  x_wide;
   tpsd_pkg::fold_type  x2_in, x2_ff;
   tpsd_pkg::power_type pw2_ff;

   always_comb begin
      a_wide = signed'({1'b0, angle});
      if (angle[AW-1] ^ angle[AW-2]) begin
         x_wide = (AW+1)'(tpsd_pkg::HALF) - a_wide;
      end else if (angle[AW-1]) begin
         x_wide = a_wide - (AW+1)'(tpsd_pkg::TURN);
      end else begin
         x_wide = a_wide;
      end
      x2_in = x_wide[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         x2_ff  <= x2_in;
         pw2_ff <= power;
      end
   end

   // Stage 3: square, then 3*2^15 - x^2/2^11
   logic signed [2*AW-1:0]          sq_full;
   logic [2*AW-1:0]                 sq_bits;
   logic [tpsd_pkg::POLY_W-1:0]     t3_in, t3_ff;
   tpsd_pkg::fold_type              x3_ff;
   tpsd_pkg::power_type             pw3_ff;

   always_comb begin
      sq_full = x2_ff * x2_ff;
      sq_bits = sq_full;
      t3_in   = tpsd_pkg::POLY_W'(tpsd_pkg::POLY_K)
              - sq_bits[tpsd_pkg::POLY_W+tpsd_pkg::SQ_SHIFT-1:tpsd_pkg::SQ_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         t3_ff  <= t3_in;
         x3_ff  <= x2_ff;
         pw3_ff <= pw2_ff;
      end
   end

   // Stage 4: x * poly, floor shift, offset to 0..SINE_SPAN
   logic signed [AW+tpsd_pkg::POLY_W:0] poly;
   logic [tpsd_pkg::SINE_W-1:0]         sine_bits;
   logic [tpsd_pkg::SINE_W-1:0]         lvl4_in, lvl4_ff;
   tpsd_pkg::power_type                 pw4_ff;

   always_comb begin
      poly      = x3_ff * signed'({1'b0, t3_ff});
      sine_bits = poly[tpsd_pkg::SINE_W+tpsd_pkg::POLY_SHIFT-1:tpsd_pkg::POLY_SHIFT];
      // two's complement wrap makes -4096..4096 land on 0..8192
      lvl4_in   = sine_bits + tpsd_pkg::SINE_W'(tpsd_pkg::SINE_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         lvl4_ff <= lvl4_in;
         pw4_ff  <= pw3_ff;
      end
   end

   // Stage 5: level * power / SINE_SPAN
   logic [tpsd_pkg::SINE_W+PW-1:0] scaled;
   logic [PW-1:0]                  v5_in, v5_ff;

   always_comb begin
      scaled = lvl4_ff * pw4_ff;
      v5_in  = scaled[PW+tpsd_pkg::SPAN_SHIFT-1:tpsd_pkg::SPAN_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         v5_ff <= v5_in;
      end
   end

   // Stage 6: divide by the timer divisor
   logic [PW+tpsd_pkg::RECIP_W-1:0] quot;
   tpsd_pkg::duty_type              duty6_in, duty6_ff;

   always_comb begin
      quot     = v5_ff * tpsd_pkg::RECIP_W'(tpsd_pkg::DIV_RECIP);
      duty6_in = quot[tpsd_pkg::DIV_SHIFT+tpsd_pkg::DUTY_W-1:tpsd_pkg::DIV_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en.s6) begin
         duty6_ff <= duty6_in;
      end
   end

   assign duty = duty6_ff;

endmodule

FILE: rtl/three_phase_sine_pwm_duty_unit.sv
// Three-phase sine PWM duty unit. Each request beat carries a mode, a 15-bit electrical angle
// and a signed command; each response beat carries the three timer compare values for phases
// at 0, 1/3 and 2/3 turn. In torque mode the angle leads a quarter turn for a positive command
// and lags a quarter turn otherwise, with the command magnitude as power; in direct mode the
// command is the power, negative clipped to zero. Power saturates at 8192. The unit accepts one
// beat per clock while ready is high and carries it through six register stages (phase angles,
// quadrant fold, square, cubic product, power scaling, divisor reciprocal multiply); the last four
// use one multiplier per phase each. Stages hold their beat only while the stage ahead is full
// and stalled, so empty slots are squeezed out and the input keeps flowing while a result waits
// at the output register until every stage is full. No state is kept between beats.
module three_phase_sine_pwm_duty_unit (
   input logic         clock,
   input logic         reset,
   tpsd_req_if.sink    req_beat,
   tpsd_rsp_if.source  rsp_beat
);

   localparam int NS = tpsd_pkg::NUM_STAGES;
   localparam int AW = tpsd_pkg::ANGLE_BITS;

   // Stage valids and advance strobes
   logic [NS:1] vld_in, vld_ff;
   logic [NS:1] adv;

   always_comb begin
      adv[NS] = !vld_ff[NS] || rsp_beat.ready;
      for (int k = NS - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = vld_ff;
      if (adv[1]) begin
         vld_in[1] = req_beat.valid;
      end
      for (int k = 2; k <= NS; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: lead/lag, power, phase angles
   logic signed [tpsd_pkg::CMD_W:0] cmd_wide;
   logic signed [tpsd_pkg::CMD_W:0] pw_wide;
   tpsd_pkg::angle_type             base;
   tpsd_pkg::angle_type             ang_a_in, ang_b_in, ang_c_in;
   tpsd_pkg::angle_type             ang_a_ff, ang_b_ff, ang_c_ff;
   tpsd_pkg::power_type             pw1_in, pw1_ff;

   always_comb begin
      cmd_wide = {req_beat.command[tpsd_pkg::CMD_W-1], req_beat.command};
      if (req_beat.mode) begin
         if (cmd_wide > 0) begin
            base    = req_beat.angle + AW'(tpsd_pkg::QUARTER);
            pw_wide = cmd_wide;
         end else begin
            base    = req_beat.angle + AW'(tpsd_pkg::TURN - tpsd_pkg::QUARTER);
            pw_wide = -cmd_wide;
         end
      end else begin
         base    = req_beat.angle;
         pw_wide = (cmd_wide < 0) ? '0 : cmd_wide;
      end
      if (pw_wide > (tpsd_pkg::CMD_W+1)'(tpsd_pkg::SINE_SPAN)) begin
         pw_wide = (tpsd_pkg::CMD_W+1)'(tpsd_pkg::SINE_SPAN);
      end
      pw1_in   = pw_wide[tpsd_pkg::POWER_W-1:0];
      ang_a_in = base;
      ang_b_in = base + AW'(tpsd_pkg::THIRD);
      ang_c_in = base + AW'(tpsd_pkg::TWO_THIRDS);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         ang_a_ff <= ang_a_in;
         ang_b_ff <= ang_b_in;
         ang_c_ff <= ang_c_in;
         pw1_ff   <= pw1_in;
      end
   end

   // Stages 2..6 per phase
   tpsd_pkg::stage_en_type phase_en;

   assign phase_en.s2 = adv[2];
   assign phase_en.s3 = adv[3];
   assign phase_en.s4 = adv[4];
   assign phase_en.s5 = adv[5];
   assign phase_en.s6 = adv[6];

   tpsd_phase u_phase_a (
      .clock (clock),
      .en    (phase_en),
      .angle (ang_a_ff),
      .power (pw1_ff),
      .duty  (rsp_beat.duty_a)
   );

   tpsd_phase u_phase_b (
      .clock (clock),
      .en    (phase_en),
      .angle (ang_b_ff),
      .power (pw1_ff),
      .duty  (rsp_beat.duty_b)
   );

   tpsd_phase u_phase_c (
      .clock (clock),
      .en    (phase_en),
      .angle (ang_c_ff),
      .power (pw1_ff),
      .duty  (rsp_beat.duty_c)
   );

   assign req_beat.ready = adv[1];
   assign rsp_beat.valid = vld_ff[NS];

endmodule

FILE: rtl/tpsd_checker.sv
// Port-level checks on the duty unit
module tpsd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_mode,
   input tpsd_pkg::command_type req_command,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input tpsd_pkg::duty_type    duty_a,
   input tpsd_pkg::duty_type    duty_b,
   input tpsd_pkg::duty_type    duty_c
);

   localparam int NS = tpsd_pkg::NUM_STAGES;

   // History of output ready and reset over the pipeline depth
   logic [NS-2:0] rdy_hist_in, rdy_hist_ff;
   logic [NS-1:0] rst_hist_in, rst_hist_ff;
   logic          flow_ok;
   logic          req_acc;
   logic          duty_zero;

   assign rdy_hist_in = {rdy_hist_ff[NS-3:0], rsp_ready};
   assign rst_hist_in = {rst_hist_ff[NS-2:0], reset};

   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_hist_ff <= '0;
      end else begin
         rdy_hist_ff <= rdy_hist_in;
      end
      rst_hist_ff <= rst_hist_in;
   end

   assign flow_ok   = (&rdy_hist_ff) && (rst_hist_ff == '0);
   assign req_acc   = req_valid && req_ready;
   assign duty_zero = (duty_a == '0) && (duty_b == '0) && (duty_c == '0);

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(duty_a) && $stable(duty_b) && $stable(duty_c))
      else $error("stalled response changed");

   // With the output drained, an accepted beat comes out through the whole pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      flow_ok && $past(req_acc, NS) |-> rsp_valid)
      else $error("response missing after pipeline depth");

   // Zero torque gives zero duties
   a_zero_torque: assert property (@(posedge clock) disable iff (reset)
      flow_ok && $past(req_acc && req_mode && (req_command == '0), NS) |-> duty_zero)
      else $error("zero torque gave nonzero duty");

   // Negative power in direct mode gives zero duties
   a_direct_neg: assert property (@(posedge clock) disable iff (reset)
      flow_ok && $past(req_acc && !req_mode && req_command[tpsd_pkg::CMD_W-1], NS)
         |-> duty_zero)
      else $error("negative direct power gave nonzero duty");

endmodule

bind three_phase_sine_pwm_duty_unit tpsd_checker u_tpsd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_beat.valid),
   .req_ready   (req_beat.ready),
   .req_mode    (req_beat.mode),
   .req_command (req_beat.command),
   .rsp_valid   (rsp_beat.valid),
   .rsp_ready   (rsp_beat.ready),
   .duty_a      (rsp_beat.duty_a),
   .duty_b      (rsp_beat.duty_b),
   .duty_c      (rsp_beat.duty_c)
);
